@@ rtl/core/rld_pkg.sv @@
package rld_pkg;

   localparam int DATA_W      = 8;
   localparam int VCN_W       = 64;
   localparam int LCN_W       = 63;
   localparam int RUNS_W      = 21;
   localparam int COUNT_W     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W  = 3;

   localparam logic [COUNT_W-1:0] MAX_FIELD_BYTES = 4'd8;
   localparam logic [RUNS_W-1:0]  RUNS_DEFAULT    = 21'h100000;

   localparam logic [CSR_ADDR_W-1:0] REG_MAX_RUNS = 3'd0;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_LEN,
      PH_OFF
   } phase_type;

   typedef enum logic [2:0] {
      KIND_RUN        = 3'd0,
      KIND_TERMINATOR = 3'd1,
      KIND_AREA_END   = 3'd2,
      KIND_MALFORMED  = 3'd3,
      KIND_OUTSIDE    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_END,
      ACT_RUN
   } act_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic [VCN_W-1:0]  start_vcn;
      logic              is_first;
      logic              is_last;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [VCN_W-1:0]  run_vcn;
      logic [VCN_W-1:0]  run_length;
      logic [LCN_W-1:0]  run_lcn;
      logic              sparse;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [VCN_W-1:0]  start_vcn;
      act_type           act;
      kind_type          end_kind;
      logic [VCN_W-1:0]  length;
      logic [VCN_W-1:0]  delta;
      logic              sparse;
      logic              at_end;
   } cmd_type;

endpackage

@@ rtl/core/rld_front.sv @@
module rld_front
   import rld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    push,
   output cmd_type cmd
);

   phase_type            phase_ff, phase_in, eff_phase;
   logic [COUNT_W-1:0]   lc_ff, lc_in, oc_ff, oc_in, bp_ff, bp_in, bp_next;
   logic [VCN_W-1:0]     len_acc_ff, len_acc_in, delta_acc_ff, delta_acc_in;
   logic [VCN_W-1:0]     len_new, delta_new, delta_ext, byte_shifted;
   logic [COUNT_W-1:0]   hdr_lc, hdr_oc;
   logic                 hdr_zero, hdr_bad, len_done, off_done, at_end;

   always_comb begin
      eff_phase    = req.is_first ? PH_HEADER : phase_ff;
      at_end       = req.is_last;
      hdr_lc       = req.data_byte[3:0];
      hdr_oc       = req.data_byte[7:4];
      hdr_zero     = (req.data_byte == '0);
      hdr_bad      = (hdr_lc == '0) || (hdr_lc > MAX_FIELD_BYTES) ||
                     (hdr_oc > MAX_FIELD_BYTES);
      bp_next      = bp_ff + 4'd1;
      byte_shifted = {{(VCN_W-DATA_W){1'b0}}, req.data_byte} << {bp_ff[2:0], 3'b000};
      len_new      = len_acc_ff | byte_shifted;
      delta_new    = delta_acc_ff | byte_shifted;
      len_done     = (bp_next >= lc_ff);
      off_done     = (bp_next >= oc_ff);
      for (int i = 0; i < 8; i++) begin
         delta_ext[i*8 +: 8] = (4'(i) >= oc_ff) ? {8{req.data_byte[7]}} : delta_new[i*8 +: 8];
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (eff_phase)
            PH_IDLE:   phase_in = PH_IDLE;
            PH_HEADER: phase_in = (hdr_zero || hdr_bad || at_end) ? PH_IDLE : PH_LEN;
            PH_LEN: begin
               if (at_end) begin
                  phase_in = PH_IDLE;
               end else if (len_done) begin
                  phase_in = (oc_ff == '0) ? PH_HEADER : PH_OFF;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_OFF: begin
               if (at_end) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = off_done ? PH_HEADER : PH_OFF;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // field registers and command
   always_comb begin
      lc_in          = lc_ff;
      oc_in          = oc_ff;
      bp_in          = bp_ff;
      len_acc_in     = len_acc_ff;
      delta_acc_in   = delta_acc_ff;
      cmd.start      = req.is_first;
      cmd.start_vcn  = req.start_vcn;
      cmd.act        = ACT_NONE;
      cmd.end_kind   = KIND_MALFORMED;
      cmd.length     = len_acc_ff;
      cmd.delta      = delta_ext;
      cmd.sparse     = 1'b0;
      cmd.at_end     = at_end;
      unique case (eff_phase)
         PH_IDLE: begin
         end
         PH_HEADER: begin
            lc_in        = hdr_lc;
            oc_in        = hdr_oc;
            bp_in        = '0;
            len_acc_in   = '0;
            delta_acc_in = '0;
            if (hdr_zero) begin
               cmd.act      = ACT_END;
               cmd.end_kind = KIND_TERMINATOR;
            end else if (hdr_bad || at_end) begin
               cmd.act      = ACT_END;
            end
         end
         PH_LEN: begin
            len_acc_in = len_new;
            bp_in      = len_done ? '0 : bp_next;
            cmd.length = len_new;
            if (len_done && (oc_ff == '0)) begin
               cmd.act    = ACT_RUN;
               cmd.sparse = 1'b1;
            end else if (at_end) begin
               cmd.act    = ACT_END;
            end
         end
         PH_OFF: begin
            delta_acc_in = delta_new;
            bp_in        = bp_next;
            if (off_done) begin
               cmd.act = ACT_RUN;
            end else if (at_end) begin
               cmd.act = ACT_END;
            end
         end
         default: begin
         end
      endcase
      push = accept && (req.is_first || (cmd.act != ACT_NONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lc_ff        <= lc_in;
         oc_ff        <= oc_in;
         bp_ff        <= bp_in;
         len_acc_ff   <= len_acc_in;
         delta_acc_ff <= delta_acc_in;
      end
   end

endmodule

@@ rtl/core/rld_queue.sv @@
module rld_queue
   import rld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/rld_back.sv @@
module rld_back
   import rld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [RUNS_W-1:0] max_runs,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload
);

   logic [LCN_W-1:0]  lcn_ff, lcn_in, base_lcn;
   logic [VCN_W-1:0]  vcn_ff, vcn_in, base_vcn;
   logic [RUNS_W-1:0] runs_ff, runs_in, base_runs;
   logic              dead_ff, dead_in, base_dead;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [VCN_W:0]    lcn_sum, vcn_sum;
   logic              out_free, lcn_fail, run_bad, emit;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      pop       = head_valid && out_free && !pending_ff;
      base_vcn  = head_cmd.start ? head_cmd.start_vcn : vcn_ff;
      base_lcn  = head_cmd.start ? '0 : lcn_ff;
      base_runs = head_cmd.start ? '0 : runs_ff;
      base_dead = head_cmd.start ? 1'b0 : dead_ff;
      lcn_sum   = {2'b00, base_lcn} + {head_cmd.delta[VCN_W-1], head_cmd.delta};
      vcn_sum   = {1'b0, base_vcn} + {1'b0, head_cmd.length};
      lcn_fail  = !head_cmd.sparse && (lcn_sum[VCN_W] || lcn_sum[VCN_W-1]);
      run_bad   = (head_cmd.length == '0) || vcn_sum[VCN_W] || (base_runs >= max_runs);
   end

   always_comb begin
      lcn_in     = lcn_ff;
      vcn_in     = vcn_ff;
      runs_in    = runs_ff;
      dead_in    = dead_ff;
      pending_in = pending_ff;
      emit       = 1'b0;
      rsp_in     = '0;
      rsp_in.last = 1'b1;
      if (pending_ff) begin
         if (out_free) begin
            emit        = 1'b1;
            rsp_in.kind = KIND_AREA_END;
            pending_in  = 1'b0;
         end
      end else if (pop) begin
         vcn_in  = base_vcn;
         lcn_in  = base_lcn;
         runs_in = base_runs;
         dead_in = base_dead;
         if (!base_dead) begin
            unique case (head_cmd.act)
               ACT_NONE: begin
               end
               ACT_END: begin
                  emit        = 1'b1;
                  rsp_in.kind = head_cmd.end_kind;
                  dead_in     = 1'b1;
               end
               ACT_RUN: begin
                  emit    = 1'b1;
                  if (lcn_fail) begin
                     rsp_in.kind = KIND_OUTSIDE;
                     dead_in     = 1'b1;
                  end else if (run_bad) begin
                     rsp_in.kind = KIND_MALFORMED;
                     dead_in     = 1'b1;
                  end else begin
                     rsp_in.kind       = KIND_RUN;
                     rsp_in.run_vcn    = base_vcn;
                     rsp_in.run_length = head_cmd.length;
                     rsp_in.run_lcn    = head_cmd.sparse ? '0 : lcn_sum[LCN_W-1:0];
                     rsp_in.sparse     = head_cmd.sparse;
                     rsp_in.last       = !head_cmd.at_end;
                     vcn_in            = vcn_sum[VCN_W-1:0];
                     runs_in           = base_runs + 1'b1;
                     if (!head_cmd.sparse) begin
                        lcn_in = lcn_sum[LCN_W-1:0];
                     end
                     pending_in = head_cmd.at_end;
                     dead_in    = head_cmd.at_end;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
         dead_ff      <= 1'b1;
         runs_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
         dead_ff      <= dead_in;
         runs_ff      <= runs_in;
      end
   end

   always_ff @(posedge clock) begin
      lcn_ff <= lcn_in;
      vcn_ff <= vcn_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/run_list_decoder.sv @@
// run_list_decoder: streaming decoder of a file-system run list
//
// req channel: one raw byte of the run list per item, with the starting
// virtual cluster, a first-byte flag and a last-byte flag. rsp channel: one
// item per decoded run or per list end (terminator, area end, malformed,
// outside volume); last marks the final item caused by one byte.
// csr port: register 0 at byte address 0 holds max_runs (21 bits).
//
// Throughput is one byte per cycle until the queue fills. The front end
// parses bytes as they are accepted and writes one command per relevant byte
// into a four-entry queue; the back end takes one command per cycle while
// its output is free, adds the cluster delta, checks the run and writes the
// result register. A byte that completes a run at the area end gives two
// items and holds the back end for the area end item. When rsp_ready is
// low the result register holds, the queue fills, and req_ready drops once
// four commands wait.
// Reset empties the queue and result register, sets max_runs to 2^20 and
// leaves the decoder idle until a byte with is_first arrives.
module run_list_decoder
   import rld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [RUNS_W-1:0] max_runs_ff;
   logic              accept, push, full, pop, head_valid;
   cmd_type           push_cmd, head_cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MAX_RUNS) ? {{(32-RUNS_W){1'b0}}, max_runs_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_runs_ff <= RUNS_DEFAULT;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == REG_MAX_RUNS)) begin
         max_runs_ff <= csr_pwdata[RUNS_W-1:0];
      end
   end

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   rld_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .cmd    (push_cmd)
   );

   rld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   rld_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_runs    (max_runs_ff),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a run item ahead of an area end is followed right away by the end item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_payload.kind == KIND_RUN) && !rsp_payload.last
      |=> rsp_valid && (rsp_payload.kind == KIND_AREA_END) && rsp_payload.last)
      else $error("area end item missing after run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_RUN) |-> (rsp_payload.run_length != '0))
      else $error("run item with zero length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != KIND_RUN)
      |-> rsp_payload.last && (rsp_payload.run_length == '0) && !rsp_payload.sparse)
      else $error("end item carries run fields");

endmodule

@@ tb/tb_run_list_decoder.sv @@
module tb_run_list_decoder;
   import rld_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [VCN_W-1:0] LCN_LIMIT = {1'b0, {LCN_W{1'b1}}};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   run_list_decoder i_dut (.*);

   req_type byte_queue[$];
   rsp_type due_results[$];
   rsp_type step_out[$];
   int      bytes_queued;
   int      bytes_taken;
   int      stim_count;
   int      mismatches;
   int      cycle_count;
   int      req_gap;
   int      rsp_stall;
   bit      idle_on;
   logic    req_taken_q;

   // decoder state as the checker sees it
   phase_type          ph;
   logic [COUNT_W-1:0] len_cnt;
   logic [COUNT_W-1:0] off_cnt;
   logic [COUNT_W-1:0] byte_pos;
   logic [VCN_W-1:0]   len_acc;
   logic [VCN_W-1:0]   delta_acc;
   logic [VCN_W-1:0]   lcn_run;
   logic [VCN_W-1:0]   vcn_next;
   logic [RUNS_W-1:0]  run_count;
   logic [RUNS_W-1:0]  max_runs_cfg;

   function automatic logic [VCN_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic close_list(kind_type k);
      rsp_type r;
      r = '0;
      r.kind = k;
      step_out.insert(step_out.size(), r);
      ph = PH_IDLE;
   endtask

   task automatic complete_run(bit sp, bit tail);
      logic [VCN_W-1:0] d;
      logic [VCN_W-1:0] mag;
      logic [VCN_W-1:0] s;
      logic [VCN_W-1:0] lcn;
      rsp_type          r;
      lcn = '0;
      if (!sp) begin
         d = delta_acc;
         if (off_cnt < MAX_FIELD_BYTES && d[8*off_cnt-1])
            d = d | ({VCN_W{1'b1}} << (8 * off_cnt));
         if (!d[VCN_W-1]) begin
            s = lcn_run + d;
            if (s > LCN_LIMIT) begin
               close_list(KIND_OUTSIDE);
               return;
            end
            lcn_run = s;
         end else begin
            mag = ~d + 1'b1;
            if (mag > lcn_run) begin
               close_list(KIND_OUTSIDE);
               return;
            end
            lcn_run = lcn_run - mag;
         end
         lcn = lcn_run;
      end
      if (len_acc == '0 || vcn_next > ~len_acc || run_count >= max_runs_cfg) begin
         close_list(KIND_MALFORMED);
         return;
      end
      r = '0;
      r.kind = KIND_RUN;
      r.run_vcn = vcn_next;
      r.run_length = len_acc;
      r.run_lcn = lcn[LCN_W-1:0];
      r.sparse = sp;
      step_out.insert(step_out.size(), r);
      vcn_next = vcn_next + len_acc;
      run_count = run_count + 1'b1;
      ph = PH_HEADER;
      if (tail)
         close_list(KIND_AREA_END);
   endtask

   task automatic decode_byte(req_type item);
      logic [DATA_W-1:0] b;
      rsp_type           r;
      b = item.data_byte;
      step_out.delete();
      if (item.is_first) begin
         ph = PH_HEADER;
         vcn_next = item.start_vcn;
         lcn_run = '0;
         run_count = '0;
         len_cnt = '0;
         off_cnt = '0;
         byte_pos = '0;
         len_acc = '0;
         delta_acc = '0;
      end
      case (ph)
         PH_HEADER: begin
            if (b == '0) begin
               close_list(KIND_TERMINATOR);
            end else begin
               len_cnt = b[3:0];
               off_cnt = b[7:4];
               if (len_cnt == '0 || len_cnt > MAX_FIELD_BYTES || off_cnt > MAX_FIELD_BYTES ||
                   item.is_last) begin
                  close_list(KIND_MALFORMED);
               end else begin
                  byte_pos = '0;
                  len_acc = '0;
                  delta_acc = '0;
                  ph = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            len_acc = len_acc | (VCN_W'(b) << (8 * byte_pos[2:0]));
            byte_pos = byte_pos + 1'b1;
            if (byte_pos >= len_cnt && off_cnt == '0) begin
               complete_run(1'b1, item.is_last);
            end else begin
               if (byte_pos >= len_cnt) begin
                  byte_pos = '0;
                  ph = PH_OFF;
               end
               if (item.is_last)
                  close_list(KIND_MALFORMED);
            end
         end
         PH_OFF: begin
            delta_acc = delta_acc | (VCN_W'(b) << (8 * byte_pos[2:0]));
            byte_pos = byte_pos + 1'b1;
            if (byte_pos >= off_cnt)
               complete_run(1'b0, item.is_last);
            else if (item.is_last)
               close_list(KIND_MALFORMED);
         end
         default: ;
      endcase
      if (step_out.size() > 0) begin
         r = step_out.pop_back();
         r.last = 1'b1;
         step_out.insert(step_out.size(), r);
      end
      foreach (step_out[i])
         due_results.insert(due_results.size(), step_out[i]);
   endtask

   task automatic log_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected kind %0d vcn %h len %h lcn %h sparse %b last %b", what,
                  want.kind, want.run_vcn, want.run_length, want.run_lcn, want.sparse, want.last);
         $display("   actual kind %0d vcn %h len %h lcn %h sparse %b last %b",
                  got.kind, got.run_vcn, got.run_length, got.run_lcn, got.sparse, got.last);
      end
   endtask

   task automatic queue_byte(logic [DATA_W-1:0] b, bit head, bit tail, logic [VCN_W-1:0] vcn,
                             bit counts);
      req_type item;
      item.data_byte = b;
      item.start_vcn = head ? vcn : rand64();
      item.is_first = head;
      item.is_last = tail;
      byte_queue.insert(byte_queue.size(), item);
      bytes_queued++;
      if (counts)
         stim_count++;
   endtask

   task automatic add_directed();
      queue_byte(8'h11, 1'b1, 1'b0, 64'h10, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'h7F, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b0, '0, 1'b1);
      // ignored while idle
      queue_byte(8'h55, 1'b0, 1'b0, '0, 1'b0);
      // virtual cluster overflow
      queue_byte(8'h01, 1'b1, 1'b0, '1, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b0, '0, 1'b1);
      // bad headers
      queue_byte(8'h09, 1'b1, 1'b0, '0, 1'b1);
      queue_byte(8'h91, 1'b1, 1'b0, '0, 1'b1);
      queue_byte(8'h10, 1'b1, 1'b0, '0, 1'b1);
      // area end on a nonzero header, then terminator on the last byte
      queue_byte(8'h11, 1'b1, 1'b1, '0, 1'b1);
      queue_byte(8'h00, 1'b1, 1'b1, '0, 1'b1);
      // delta below cluster zero
      queue_byte(8'h11, 1'b1, 1'b0, '0, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b0, '0, 1'b1);
      // run completed at area end
      queue_byte(8'h11, 1'b1, 1'b0, '0, 1'b1);
      queue_byte(8'h02, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'h03, 1'b0, 1'b1, '0, 1'b1);
      // truncated length field
      queue_byte(8'h12, 1'b1, 1'b0, '0, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b1, '0, 1'b1);
      // zero length
      queue_byte(8'h11, 1'b1, 1'b0, '0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b0, '0, 1'b1);
      queue_byte(8'h05, 1'b0, 1'b0, '0, 1'b1);
   endtask

   task automatic add_junk();
      int n;
      n = $urandom_range(1, 6);
      queue_byte(8'($urandom()), 1'b1, $urandom_range(0, 7) == 0, rand64(), 1'b1);
      for (int i = 0; i < n; i++)
         queue_byte(8'($urandom()), 1'b0, $urandom_range(0, 7) == 0, '0, 1'b1);
   endtask

   // ending: terminator, terminator on last byte, area end, truncation, or restart
   task automatic add_list();
      int                n_runs;
      int                ending;
      int                lc;
      int                oc;
      int                pick;
      int                cut;
      logic [VCN_W-1:0]  vcn;
      logic [DATA_W-1:0] run_bytes[$];
      bit                head;
      bit                final_run;
      n_runs = $urandom_range(1, 5);
      ending = $urandom_range(0, 9);
      vcn = ($urandom_range(0, 7) == 0) ? rand64() : VCN_W'($urandom_range(0, 4095));
      head = 1'b1;
      for (int i = 0; i < n_runs; i++) begin
         final_run = (i == n_runs - 1);
         lc = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
         pick = $urandom_range(0, 9);
         oc = (pick < 2) ? 0 : (pick < 8) ? $urandom_range(1, 3) : $urandom_range(4, 8);
         run_bytes.delete();
         run_bytes.insert(run_bytes.size(), {4'(oc), 4'(lc)});
         for (int j = 0; j < lc + oc; j++)
            run_bytes.insert(run_bytes.size(), 8'($urandom()));
         if (oc > 0) begin
            pick = $urandom_range(0, 7);
            if (pick < 5)
               run_bytes[lc + oc] = run_bytes[lc + oc] & 8'h7F;
            else if (pick < 7)
               run_bytes[lc + oc] = 8'hFF;
         end
         if (final_run && ending == 8) begin
            cut = $urandom_range(0, run_bytes.size() - 2);
            for (int j = 0; j <= cut; j++)
               queue_byte(run_bytes[j], head && j == 0, j == cut, vcn, 1'b1);
         end else begin
            for (int j = 0; j < run_bytes.size(); j++)
               queue_byte(run_bytes[j], head && j == 0,
                          final_run && (ending == 6 || ending == 7) && j == run_bytes.size() - 1,
                          vcn, 1'b1);
         end
         head = 1'b0;
      end
      if (ending <= 5)
         queue_byte(8'h00, 1'b0, ending == 5, vcn, 1'b1);
      if (ending != 9 && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            queue_byte(8'($urandom()), 1'b0, $urandom_range(0, 1) == 1, vcn, 1'b0);
   endtask

   task automatic add_random_lists(int target);
      int start;
      start = stim_count;
      while (stim_count - start < target) begin
         if ($urandom_range(0, 4) == 0)
            add_junk();
         else
            add_list();
      end
   endtask

   task automatic wait_drained();
      while (bytes_taken != bytes_queued || due_results.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_max_runs(logic [RUNS_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_MAX_RUNS;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      max_runs_cfg = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[RUNS_W-1:0] !== value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("max_runs readback: expected %0d, actual %0d", value,
                     csr_prdata[RUNS_W-1:0]);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken_q) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 6);
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken_q <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            bytes_taken++;
            decode_byte(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               log_mismatch("unexpected result", '0, rsp_payload);
            end else begin
               want = due_results.pop_front();
               if (rsp_payload.kind !== want.kind || rsp_payload.run_vcn !== want.run_vcn ||
                   rsp_payload.run_length !== want.run_length ||
                   rsp_payload.run_lcn !== want.run_lcn ||
                   rsp_payload.sparse !== want.sparse || rsp_payload.last !== want.last)
                  log_mismatch("result mismatch", want, rsp_payload);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[run_list_decoder] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_taken_q = 1'b0;
      idle_on = 1'b1;
      ph = PH_IDLE;
      len_cnt = '0;
      off_cnt = '0;
      byte_pos = '0;
      len_acc = '0;
      delta_acc = '0;
      lcn_run = '0;
      vcn_next = '0;
      run_count = '0;
      max_runs_cfg = RUNS_DEFAULT;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      set_max_runs(RUNS_DEFAULT);
      add_directed();
      add_random_lists(100);
      wait_drained();

      set_max_runs(21'd1);
      add_random_lists(100);
      wait_drained();

      set_max_runs(21'd3);
      add_random_lists(100);
      wait_drained();

      set_max_runs(RUNS_W'($urandom_range(4, RUNS_DEFAULT)));
      add_random_lists(100);
      wait_drained();

      idle_on = 1'b0;
      req_gap = 0;
      rsp_stall = 0;
      set_max_runs(21'd2);
      add_random_lists(100);
      wait_drained();

      if (mismatches == 0)
         $display("[run_list_decoder] OK");
      else
         $display("[run_list_decoder] ERROR");
      $finish;
   end

endmodule
